>>> rtl/ctsm_pkg.sv
// ----------------------------------------------------------------------------
// ctsm_pkg: shared types for the channel table seed merge block
// Input and result payload types, action codes, controller/datapath commands.
// ----------------------------------------------------------------------------
package ctsm_pkg;

	localparam int MAX_ROWS = 32;
	localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ROW_CW = $clog2(MAX_ROWS + 1);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 20;

	localparam logic [2:0] ACT_LOAD_ROW = 3'd0;
	localparam logic [2:0] ACT_CLR_ROWS = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_CLR_TABLES = 3'd3;
	localparam logic [2:0] ACT_SEED = 3'd4;
	localparam logic [2:0] ACT_READ = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_WACN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYSID = 1'd1;

	localparam logic [1:0] TRUST_SEED = 2'd1;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] ident;
		logic tdma_table;
		logic [19:0] net_id;
		logic [11:0] sys_id;
		logic site_known;
		logic [1:0] trust_level;
		logic [31:0] freq_base;
		logic [9:0] chan_spacing;
		logic [3:0] chan_kind;
		logic [8:0] tx_offset;
		logic [8:0] bandwidth;
	} in_item_t;

	typedef struct packed {
		logic populated;
		logic [1:0] trust_out;
		logic site_known_out;
		logic [19:0] net_id_out;
		logic [11:0] sys_id_out;
		logic [31:0] freq_base_out;
		logic [9:0] chan_spacing_out;
		logic [3:0] chan_kind_out;
		logic [8:0] tx_offset_out;
		logic [8:0] bandwidth_out;
		logic [1:0] explicit_out;
		logic [5:0] changed_count;
	} out_item_t;

	typedef struct packed {
		logic [31:0] base;
		logic [9:0] spacing;
		logic [3:0] kind;
		logic [8:0] offset;
		logic [8:0] bw;
	} nums_t;

	// commands from controller to datapath
	typedef struct packed {
		logic exec;        // perform the action of the captured item
		logic seed_start;  // reset the seed change counter
		logic row_rd;      // read row at row_idx
		logic [ROW_AW-1:0] row_idx;
		logic eval_local;  // evaluate row read last cycle, local pass
		logic eval_global; // evaluate row read last cycle, global pass
		logic scan_rd;     // read scan row at scan_idx
		logic [ROW_AW-1:0] scan_idx;
		logic scan_eval;   // compare scan row read last cycle
		logic local_commit;// write local row if allowed
		logic emit;        // load result register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [ROW_CW-1:0] row_count;
		logic sys_known;
		logic local_cand;  // evaluated row is a local candidate
		logic need_scan;   // candidate slot populated with a possible global seed
		logic scan_hit;    // global seed found
	} stat_t;

endpackage

>>> rtl/ctsm_datapath.sv
// ----------------------------------------------------------------------------
// ctsm_datapath: row store, slot tables and seeding datapath
// Executes actions under command of the controller; rows are read one at a time.
// ----------------------------------------------------------------------------
module ctsm_datapath (
	input  logic clk,
	input  logic arst_n,
	input  ctsm_pkg::in_item_t item,
	input  logic [19:0] sys_wacn,
	input  logic [11:0] sys_sysid,
	input  ctsm_pkg::cmd_t cmd,
	output ctsm_pkg::stat_t stat,
	output ctsm_pkg::out_item_t result
);
	import ctsm_pkg::*;

	typedef struct packed {
		logic [3:0] ident;
		logic tdma;
		logic [19:0] net;
		logic [11:0] sys;
	} key_t;

	key_t row_key_mem [MAX_ROWS];
	nums_t row_num_mem [MAX_ROWS];
	key_t rd_key_q;
	nums_t rd_num_q;
	logic [ROW_CW-1:0] row_count_q;

	logic [31:0] pop_q;
	logic [1:0] trust_q [32];
	logic [31:0] site_q;
	logic [19:0] tnet_q [32];
	logic [11:0] tsys_q [32];
	nums_t tnum_q [32];
	logic [15:0] mark_f_q, mark_t_q;
	logic [5:0] changed_q;
	key_t cand_q;
	nums_t cand_num_q;
	logic hit_q;
	out_item_t result_q;
	out_item_t res_d;

	logic [4:0] item_slot, rd_slot, cand_slot;
	logic rd_global, rd_local;
	logic seed_wr;
	logic [4:0] seed_slot;
	key_t seed_key;
	nums_t seed_num;
	nums_t item_num;

	assign item_slot = {item.tdma_table, item.ident};
	assign rd_slot = {rd_key_q.tdma, rd_key_q.ident};
	assign cand_slot = {cand_q.tdma, cand_q.ident};
	assign item_num = '{item.freq_base, item.chan_spacing, item.chan_kind,
		item.tx_offset, item.bandwidth};
	assign rd_global = (rd_key_q.net == '0) && (rd_key_q.sys == '0);
	assign rd_local = !rd_global && rd_key_q.net == sys_wacn && rd_key_q.sys == sys_sysid;

	// status back to the controller
	always_comb begin
		stat.row_count = row_count_q;
		stat.sys_known = (sys_wacn != '0) || (sys_sysid != '0);
		stat.local_cand = rd_local;
		stat.need_scan = pop_q[rd_slot] && trust_q[rd_slot] == TRUST_SEED
			&& tnet_q[rd_slot] == '0 && tsys_q[rd_slot] == '0 && !site_q[rd_slot];
		stat.scan_hit = hit_q;
	end

	// seed write selection
	always_comb begin
		seed_wr = 1'b0;
		seed_slot = rd_slot;
		seed_key = rd_key_q;
		seed_num = rd_num_q;
		if (cmd.local_commit) begin
			seed_wr = 1'b1;
			seed_slot = cand_slot;
			seed_key = cand_q;
			seed_num = cand_num_q;
		end else if (cmd.eval_local) begin
			seed_wr = rd_local && !pop_q[rd_slot];
		end else if (cmd.eval_global) begin
			seed_wr = rd_global && !pop_q[rd_slot];
		end
	end

	// row store
	always_ff @(posedge clk) begin
		if (cmd.exec && item.action == ACT_LOAD_ROW && row_count_q < ROW_CW'(MAX_ROWS)) begin
			row_key_mem[row_count_q[ROW_AW-1:0]] <= '{item.ident, item.tdma_table,
				item.net_id, item.sys_id};
			row_num_mem[row_count_q[ROW_AW-1:0]] <= item_num;
		end
		if (cmd.row_rd) begin
			rd_key_q <= row_key_mem[cmd.row_idx];
			rd_num_q <= row_num_mem[cmd.row_idx];
		end else if (cmd.scan_rd) begin
			rd_key_q <= row_key_mem[cmd.scan_idx];
			rd_num_q <= row_num_mem[cmd.scan_idx];
		end
	end

	// candidate hold and scan compare
	always_ff @(posedge clk) begin
		if (cmd.eval_local) begin
			cand_q <= rd_key_q;
			cand_num_q <= rd_num_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.eval_local) begin
			hit_q <= 1'b0;
		end else if (cmd.scan_eval) begin
			if (rd_global && rd_key_q.ident == cand_q.ident && rd_key_q.tdma == cand_q.tdma
				&& rd_num_q == tnum_q[cand_slot])
				hit_q <= 1'b1;
		end
	end

	// slot tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			pop_q <= '0;
			site_q <= '0;
			mark_f_q <= '0;
			mark_t_q <= '0;
			changed_q <= '0;
			for (int i = 0; i < 32; i++) begin
				trust_q[i] <= '0;
				tnet_q[i] <= '0;
				tsys_q[i] <= '0;
				tnum_q[i] <= '0;
			end
		end else begin
			if (cmd.seed_start)
				changed_q <= '0;
			if (cmd.exec) begin
				case (item.action)
					ACT_LOAD_ROW: begin
						if (row_count_q < ROW_CW'(MAX_ROWS))
							row_count_q <= row_count_q + 1'b1;
					end
					ACT_CLR_ROWS: row_count_q <= '0;
					ACT_WRITE: begin
						pop_q[item_slot] <= 1'b1;
						trust_q[item_slot] <= item.trust_level;
						site_q[item_slot] <= item.site_known;
						tnet_q[item_slot] <= item.net_id;
						tsys_q[item_slot] <= item.sys_id;
						tnum_q[item_slot] <= item_num;
					end
					ACT_CLR_TABLES: begin
						pop_q <= '0;
						site_q <= '0;
						mark_f_q <= '0;
						mark_t_q <= '0;
						for (int i = 0; i < 32; i++) begin
							trust_q[i] <= '0;
							tnet_q[i] <= '0;
							tsys_q[i] <= '0;
							tnum_q[i] <= '0;
						end
					end
					default: ;
				endcase
			end
			if (seed_wr) begin
				pop_q[seed_slot] <= 1'b1;
				trust_q[seed_slot] <= TRUST_SEED;
				site_q[seed_slot] <= 1'b0;
				tnet_q[seed_slot] <= seed_key.net;
				tsys_q[seed_slot] <= seed_key.sys;
				tnum_q[seed_slot] <= seed_num;
				if (seed_key.tdma)
					mark_t_q[seed_key.ident] <= 1'b1;
				else
					mark_f_q[seed_key.ident] <= 1'b1;
				changed_q <= changed_q + 6'd1;
			end
		end
	end

	// result of the captured action
	always_comb begin
		res_d = '0;
		if (item.action == ACT_SEED)
			res_d.changed_count = changed_q;
		else if (item.action == ACT_READ) begin
			res_d.populated = pop_q[item_slot];
			res_d.trust_out = trust_q[item_slot];
			res_d.site_known_out = site_q[item_slot];
			res_d.net_id_out = tnet_q[item_slot];
			res_d.sys_id_out = tsys_q[item_slot];
			res_d.freq_base_out = tnum_q[item_slot].base;
			res_d.chan_spacing_out = tnum_q[item_slot].spacing;
			res_d.chan_kind_out = tnum_q[item_slot].kind;
			res_d.tx_offset_out = tnum_q[item_slot].offset;
			res_d.bandwidth_out = tnum_q[item_slot].bw;
			res_d.explicit_out = {mark_t_q[item.ident], mark_f_q[item.ident]};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit)
			result_q <= res_d;
	end

	assign result = result_q;

endmodule

>>> rtl/ctsm_ctrl.sv
// ----------------------------------------------------------------------------
// ctsm_ctrl: sequencer for the channel table seed merge block
// Accepts beats, steps the seeding passes, and holds the output valid.
// ----------------------------------------------------------------------------
module ctsm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  ctsm_pkg::in_item_t in_data,
	output ctsm_pkg::in_item_t item,
	input  ctsm_pkg::stat_t stat,
	output ctsm_pkg::cmd_t cmd
);
	import ctsm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_LRD, ST_LEVAL, ST_SRD, ST_SEVAL, ST_SDONE,
		ST_COMMIT, ST_GRD, ST_GEVAL, ST_EMIT, ST_OUT
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [ROW_CW-1:0] idx_q, scan_q;
	logic [ROW_CW-1:0] n_rows;
	logic out_busy;

	assign n_rows = stat.row_count;
	assign item = item_q;
	assign out_busy = out_valid && !out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		cmd.row_idx = idx_q[ROW_AW-1:0];
		cmd.scan_idx = scan_q[ROW_AW-1:0];
		case (state_q)
			ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.seed_start = 1'b1;
			end
			ST_LRD, ST_GRD: cmd.row_rd = 1'b1;
			ST_LEVAL: cmd.eval_local = 1'b1;
			ST_SRD: cmd.scan_rd = 1'b1;
			ST_SEVAL: cmd.scan_eval = 1'b1;
			ST_COMMIT: cmd.local_commit = 1'b1;
			ST_GEVAL: cmd.eval_global = 1'b1;
			ST_EMIT: cmd.emit = !out_busy;
			default: ;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			idx_q <= '0;
			scan_q <= '0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					idx_q <= '0;
					if (item_q.action != ACT_SEED || n_rows == '0)
						state_q <= ST_EMIT;
					else if (stat.sys_known)
						state_q <= ST_LRD;
					else
						state_q <= ST_GRD;
				end
				ST_LRD: state_q <= ST_LEVAL;
				ST_LEVAL: begin
					scan_q <= '0;
					if (stat.local_cand && stat.need_scan) begin
						state_q <= ST_SRD;
					end else if (idx_q + 1'b1 == n_rows) begin
						idx_q <= '0;
						state_q <= ST_GRD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_LRD;
					end
				end
				ST_SRD: state_q <= ST_SEVAL;
				ST_SEVAL: begin
					if (scan_q + 1'b1 == n_rows)
						state_q <= ST_SDONE;
					else begin
						scan_q <= scan_q + 1'b1;
						state_q <= ST_SRD;
					end
				end
				// replace only a slot that still holds a global seed
				ST_SDONE: begin
					if (stat.scan_hit)
						state_q <= ST_COMMIT;
					else if (idx_q + 1'b1 == n_rows) begin
						idx_q <= '0;
						state_q <= ST_GRD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_LRD;
					end
				end
				ST_COMMIT: begin
					if (idx_q + 1'b1 == n_rows) begin
						idx_q <= '0;
						state_q <= ST_GRD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_LRD;
					end
				end
				ST_GRD: state_q <= ST_GEVAL;
				ST_GEVAL: begin
					if (idx_q + 1'b1 == n_rows)
						state_q <= ST_EMIT;
					else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_GRD;
					end
				end
				// wait until the output register is free
				ST_EMIT: begin
					if (!out_busy)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_busy) begin
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/channel_table_seed_merge.sv
// ----------------------------------------------------------------------------
// channel_table_seed_merge: band-plan row store and channel identifier tables
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid/in_ready with in_data, one action per beat.
//   out channel: out_valid/out_ready with out_data, exactly one beat per
//   input beat, in order; fields not used by an action read zero.
//   cfg port: cfg_we, cfg_idx, cfg_data write system_wacn (0) and
//   system_sysid (1); write only while the block is idle.
// sequence
//   load, clear, write and read: accept, execute, emit, then out_valid.
//   seed: a global pass over the N rows, preceded by a local pass when
//   the system is known; each local row landing on a slot that may hold a
//   global seed adds a scan of all rows, and a commit when it replaces that seed.
// flow
//   one item at a time; the next beat is taken while an earlier result may
//   still wait in the output reg.
// reset
//   row count zero, all slots empty, marks, seed count and config registers cleared.
// stall
//   a held result keeps out_data stable; the next item runs up to its result
//   and waits there, so in_ready stays low until the receiver takes a beat.
// ----------------------------------------------------------------------------
module channel_table_seed_merge (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ctsm_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ctsm_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [ctsm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ctsm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ctsm_pkg::*;

	logic [19:0] wacn_q;
	logic [11:0] sysid_q;
	cmd_t cmd;
	stat_t stat;
	in_item_t item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wacn_q <= '0;
			sysid_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == REG_WACN)
				wacn_q <= cfg_data;
			if (cfg_idx == REG_SYSID)
				sysid_q <= cfg_data[11:0];
		end
	end

	ctsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.in_data(in_data), .item(item), .stat(stat), .cmd(cmd)
	);

	ctsm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(item),
		.sys_wacn(wacn_q), .sys_sysid(sysid_q),
		.cmd(cmd), .stat(stat), .result(out_data)
	);

`ifndef SYNTHESIS
	// result stays put while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");
	// valid holds until the beat is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	// seeding count bounded by slot count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.changed_count <= 6'd32)
		else $error("changed count out of range");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for channel_table_seed_merge
// Drives actions over the valid/ready input, keeps its own copy of the row
// store, slot tables and marks, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb;
	import ctsm_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	localparam logic [2:0] ACT_BAD_A = 3'd6;
	localparam logic [2:0] ACT_BAD_B = 3'd7;
	localparam int IN_W = $bits(in_item_t);

	typedef struct packed {
		logic populated;
		logic [1:0] trust;
		logic site;
		logic [19:0] net;
		logic [11:0] sys;
	} slot_tag_t;

	typedef struct packed {
		logic [3:0] ident;
		logic tdma;
		logic [19:0] net;
		logic [11:0] sys;
	} row_key_t;

	channel_table_seed_merge u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// shadow state of the block
	logic [19:0] sys_wacn;
	logic [11:0] sys_sysid;
	row_key_t plan_keys [MAX_ROWS];
	nums_t plan_nums [MAX_ROWS];
	int plan_count;
	slot_tag_t tags [32];
	nums_t nums [32];
	logic [1:0] marks [16];

	out_item_t pending_results [$];
	int mismatches;
	bit failed;
	bit idle_on;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// slot still holds an untouched global seed for the row's identifier
	function automatic bit holds_global_seed(input int r, input int s);
		if (tags[s].trust != TRUST_SEED || tags[s].net != 0 || tags[s].sys != 0
				|| tags[s].site)
			return 1'b0;
		for (int i = 0; i < plan_count; i++)
			if (plan_keys[i].ident == plan_keys[r].ident
					&& plan_keys[i].tdma == plan_keys[r].tdma
					&& plan_keys[i].net == 0 && plan_keys[i].sys == 0
					&& plan_nums[i] == nums[s])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void seed_slot(input int r, input int s);
		tags[s] = '{1'b1, TRUST_SEED, 1'b0, plan_keys[r].net, plan_keys[r].sys};
		nums[s] = plan_nums[r];
		marks[plan_keys[r].ident] |= plan_keys[r].tdma ? 2'b10 : 2'b01;
	endfunction

	function automatic int seed_tables();
		int changed;
		int s;
		changed = 0;
		if (sys_wacn != 0 || sys_sysid != 0)
			for (int i = 0; i < plan_count; i++) begin
				if ((plan_keys[i].net == 0 && plan_keys[i].sys == 0)
						|| plan_keys[i].net != sys_wacn || plan_keys[i].sys != sys_sysid)
					continue;
				s = int'({plan_keys[i].tdma, plan_keys[i].ident});
				if (tags[s].populated && !holds_global_seed(i, s))
					continue;
				seed_slot(i, s);
				changed++;
			end
		for (int i = 0; i < plan_count; i++) begin
			if (plan_keys[i].net != 0 || plan_keys[i].sys != 0)
				continue;
			s = int'({plan_keys[i].tdma, plan_keys[i].ident});
			if (tags[s].populated)
				continue;
			seed_slot(i, s);
			changed++;
		end
		return changed;
	endfunction

	// apply one action to the shadow state and return its result
	function automatic out_item_t predict_result(input in_item_t it);
		out_item_t r;
		int s;
		nums_t nv;
		r = '0;
		s = int'({it.tdma_table, it.ident});
		nv = '{it.freq_base, it.chan_spacing, it.chan_kind, it.tx_offset, it.bandwidth};
		case (it.action)
			ACT_LOAD_ROW: begin
				if (plan_count < MAX_ROWS) begin
					plan_keys[plan_count] = '{it.ident, it.tdma_table, it.net_id, it.sys_id};
					plan_nums[plan_count] = nv;
					plan_count++;
				end
			end
			ACT_CLR_ROWS: plan_count = 0;
			ACT_WRITE: begin
				tags[s] = '{1'b1, it.trust_level, it.site_known, it.net_id, it.sys_id};
				nums[s] = nv;
			end
			ACT_CLR_TABLES: begin
				for (int i = 0; i < 32; i++) begin
					tags[i] = '0;
					nums[i] = '0;
				end
				for (int i = 0; i < 16; i++)
					marks[i] = '0;
			end
			ACT_SEED: r.changed_count = 6'(seed_tables());
			ACT_READ: begin
				r.populated = tags[s].populated;
				r.trust_out = tags[s].trust;
				r.site_known_out = tags[s].site;
				r.net_id_out = tags[s].net;
				r.sys_id_out = tags[s].sys;
				r.freq_base_out = nums[s].base;
				r.chan_spacing_out = nums[s].spacing;
				r.chan_kind_out = nums[s].kind;
				r.tx_offset_out = nums[s].offset;
				r.bandwidth_out = nums[s].bw;
				r.explicit_out = marks[it.ident];
			end
			default: ;
		endcase
		return r;
	endfunction

	// send one beat and record its expected result; valid is dropped by idling
	task automatic send_beat(input in_item_t it);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		pending_results.push_back(predict_result(it));
		do @(posedge clk); while (!in_ready);
	endtask

	// receiver with random stall bursts and an optional long hold-off
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 13);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				failed = 1'b1;
				if (mismatches < 10)
					$display("unexpected result beat %h", out_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					failed = 1'b1;
					if (mismatches < 10)
						$display("mismatch: expected %h actual %h", want, out_data);
					mismatches++;
				end
			end
		end
	end

	function automatic in_item_t random_item(input logic [2:0] act);
		in_item_t it;
		it = IN_W'({$urandom, $urandom, $urandom, $urandom});
		it.action = act;
		// half the owners are global or the current system, the rest random
		case ($urandom_range(0, 3))
			0: begin it.net_id = '0; it.sys_id = '0; end
			1: begin it.net_id = sys_wacn; it.sys_id = sys_sysid; end
			default: ;
		endcase
		if ($urandom_range(0, 1))
			it.freq_base = 32'($urandom_range(0, 3));
		if ($urandom_range(0, 2) == 0)
			it.trust_level = TRUST_SEED;
		return it;
	endfunction

	task automatic wait_drained();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_WACN)
			sys_wacn = val;
		else
			sys_sysid = val[11:0];
	endtask

	task automatic set_system(input logic [19:0] w, input logic [11:0] s);
		wait_drained();
		write_reg(REG_WACN, w);
		write_reg(REG_SYSID, {8'd0, s});
		cfg_we <= 1'b0;
	endtask

	// extremes, every action, full store, unknown codes
	task automatic test_directed();
		in_item_t it;
		it = '1;
		it.action = ACT_WRITE;
		send_beat(it);
		it.action = ACT_READ;
		send_beat(it);
		it = '0;
		it.action = ACT_READ;
		send_beat(it);
		it.action = ACT_SEED;
		send_beat(it);
		it.action = ACT_BAD_A;
		send_beat(it);
		it = '1;
		it.action = ACT_BAD_B;
		send_beat(it);
		// two global rows, then a row of the current system on the second one's slot
		it = '0;
		it.action = ACT_LOAD_ROW;
		it.ident = 4'hF;
		it.freq_base = 32'hFFFF_FFFF;
		send_beat(it);
		it.tdma_table = 1'b1;
		send_beat(it);
		it.net_id = sys_wacn;
		it.sys_id = sys_sysid;
		it.freq_base = 32'd7;
		send_beat(it);
		it.action = ACT_SEED;
		send_beat(it);
		send_beat(it);
		it.action = ACT_READ;
		send_beat(it);
		it.tdma_table = 1'b0;
		send_beat(it);
		it.action = ACT_CLR_TABLES;
		send_beat(it);
		it.action = ACT_SEED;
		send_beat(it);
		it.action = ACT_READ;
		send_beat(it);
		// overfill the row store
		for (int i = 0; i < MAX_ROWS + 3; i++)
			send_beat(random_item(ACT_LOAD_ROW));
		send_beat(random_item(ACT_SEED));
		send_beat(random_item(ACT_CLR_ROWS));
		send_beat(random_item(ACT_SEED));
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 40; i++)
			send_beat(random_item(ACT_READ));
	endtask

	// well-formed sessions (clear, load rows, write entries, seed, read back), mixed with single random actions
	task automatic test_random(input int count);
		int sent;
		int nrows;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 3) == 0) begin
				send_beat(random_item(3'($urandom_range(0, 7))));
				sent++;
				continue;
			end
			send_beat(random_item($urandom_range(0, 1) ? ACT_CLR_ROWS : ACT_CLR_TABLES));
			nrows = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 36);
			for (int i = 0; i < nrows; i++)
				send_beat(random_item(ACT_LOAD_ROW));
			for (int i = 0; i < $urandom_range(0, 4); i++)
				send_beat(random_item(ACT_WRITE));
			send_beat(random_item(ACT_SEED));
			for (int i = 0; i < 6; i++)
				send_beat(random_item(ACT_READ));
			sent += nrows + 8;
		end
	endtask

	initial begin
		mismatches = 0;
		failed = 1'b0;
		idle_on = 1'b1;
		hold_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		sys_wacn = '0;
		sys_sysid = '0;
		plan_count = 0;
		for (int i = 0; i < 32; i++) begin
			tags[i] = '0;
			nums[i] = '0;
		end
		for (int i = 0; i < 16; i++)
			marks[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_system(20'hFFFFF, 12'hFFF);
		test_directed();
		test_backpressure();
		set_system(20'h12345, 12'h0);
		test_random(300);
		set_system(20'h0, 12'h001);
		test_random(250);
		set_system(20'h0, 12'h0);
		test_random(250);
		set_system(20'($urandom_range(1, 20'hFFFFF)), 12'($urandom_range(1, 4095)));
		test_random(200);
		idle_on = 1'b0;
		test_random(150);

		wait_drained();
		if (!failed && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
